@@ rtl/pvm_pkg.sv @@
// Package: shared types and constants for the PCM voice mixer.
`timescale 1ns / 1ps

package pvm_pkg;

    // Fixed field widths of the transaction payloads
    localparam int SAMPLE_W = 16;
    localparam int ID_W     = 3;
    localparam int OFFSET_W = 12;
    localparam int LENGTH_W = 13;
    localparam int ACTIVE_W = 3;

    // Command codes of an input transaction
    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_TRIGGER = 2'd1,
        CMD_WRITE   = 2'd2,
        CMD_LENGTH  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                        command;
        logic [ID_W-1:0]             sound_id;
        logic [OFFSET_W-1:0]         sample_offset;
        logic signed [SAMPLE_W-1:0]  sample_value;
        logic [LENGTH_W-1:0]         length_value;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]  left_sample;
        logic signed [SAMPLE_W-1:0]  right_sample;
        logic [ACTIVE_W-1:0]         active_voices;
    } t_out_item;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH,
        ST_DIVIDE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic exec;        // carry out a trigger, sample write or length set
        logic tick_start;  // clear the accumulator, rewind the voice index
        logic scan_step;   // visit the voice under the index
        logic div_start;   // launch the averaging divide
        logic out_load;    // capture the mixed frame into the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic scan_last;   // index is on the last voice
        logic div_done;    // quotient is ready
    } t_dp_sts;

endpackage

@@ rtl/pvm_div.sv @@
// Sequential signed-by-unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module pvm_div #(
    parameter int SUM_W = 19,
    parameter int CNT_W = 3
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0]        i_divisor,
    output logic                    o_done,
    output logic signed [SUM_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [SUM_W-1:0]  r_quo, n_quo;
    logic [CNT_W-1:0]  r_div, n_div;
    logic              r_neg, n_neg;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;

    // Restoring step on the magnitude; sign applied at the end
    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_step = r_step;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        n_neg  = r_neg;
        trial  = {r_rem, r_quo[SUM_W-1]};
        diff   = trial - {1'b0, r_div};
        if (i_start) begin
            n_busy = 1'b1;
            n_done = 1'b0;
            n_step = STEP_W'(SUM_W);
            n_rem  = '0;
            n_div  = i_divisor;
            n_neg  = i_dividend[SUM_W-1];
            n_quo  = i_dividend[SUM_W-1] ? unsigned'(-i_dividend) : unsigned'(i_dividend);
        end else if (r_busy) begin
            if (trial >= {1'b0, r_div}) begin
                n_rem = diff[CNT_W-1:0];
                n_quo = {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                n_rem = trial[CNT_W-1:0];
                n_quo = {r_quo[SUM_W-2:0], 1'b0};
            end
            n_step = r_step - 1'b1;
            if (r_step == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_div  <= n_div;
        r_neg  <= n_neg;
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -signed'(r_quo) : signed'(r_quo);

endmodule

@@ rtl/pvm_dp.sv @@
// Datapath: voice registers, length and sample memories, accumulator, divider.
`timescale 1ns / 1ps

module pvm_dp #(
    parameter int NUM_VOICES = 4,
    parameter int NUM_SOUNDS = 8,
    parameter int SLOT_DEPTH = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pvm_pkg::t_in_item i_item,
    input  pvm_pkg::t_dp_cmd  i_cmd,
    output pvm_pkg::t_dp_sts  o_sts,
    output pvm_pkg::t_out_item o_item
);

    localparam int VID_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int SID_W     = (NUM_SOUNDS > 1) ? $clog2(NUM_SOUNDS) : 1;
    localparam int IDX_W     = (SID_W > pvm_pkg::ID_W) ? SID_W : pvm_pkg::ID_W;
    localparam int POS_W     = $clog2(SLOT_DEPTH);
    localparam int LEN_W     = $clog2(SLOT_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_SOUNDS * SLOT_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int CNT_W     = $clog2(NUM_VOICES + 1);
    localparam int SUM_W     = pvm_pkg::SAMPLE_W + CNT_W;

    // Voice state
    logic [NUM_VOICES-1:0] r_busy;
    logic [SID_W-1:0]      r_vsound [NUM_VOICES];
    logic [POS_W-1:0]      r_vpos   [NUM_VOICES];
    logic [VID_W-1:0]      r_vidx;

    // Sound lengths: present bits double as valid bits for the length memory
    logic [NUM_SOUNDS-1:0] r_present;
    logic [LEN_W-1:0]      r_len_mem [NUM_SOUNDS];
    logic [LEN_W-1:0]      r_len_q;
    logic                  r_len_ok;

    // Sample memory
    logic signed [pvm_pkg::SAMPLE_W-1:0] r_smp_mem [MEM_DEPTH];
    logic signed [pvm_pkg::SAMPLE_W-1:0] r_smp_q;

    // Scan pipeline
    logic              r_s1_vld;
    logic [VID_W-1:0]  r_s1_vidx;
    logic              r_s1_busy;
    logic [POS_W-1:0]  r_s1_pos;
    logic [SID_W-1:0]  r_s1_sound;
    logic              r_s2_vld;

    // Accumulator and output
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    pvm_pkg::t_out_item      r_out;

    // Command decode
    logic [IDX_W-1:0]  id_ext;
    logic [SID_W-1:0]  id_idx;
    logic              id_ok;
    logic              free_found;
    logic [VID_W-1:0]  free_idx;
    logic              trig_go;
    logic              wr_go;
    logic              len_go;
    logic [AW-1:0]     wr_addr;
    logic [31:0]       len32;
    logic [31:0]       len_sat;

    // Voice evaluation
    logic [LEN_W-1:0]  len_eff;
    logic [LEN_W-1:0]  pos_ext;
    logic [LEN_W-1:0]  pos_inc;
    logic              s2_upd;
    logic              s2_play;
    logic              s2_busy_n;
    logic [POS_W-1:0]  s2_pos_n;
    logic [AW-1:0]     rd_addr;

    logic signed [SUM_W-1:0] quotient;
    logic                    div_done;
    logic [31:0]             cnt32;
    logic signed [pvm_pkg::SAMPLE_W-1:0] avg;

    // Decode of trigger, sample write and length set
    always_comb begin
        id_ext     = IDX_W'(i_item.sound_id);
        id_idx     = id_ext[SID_W-1:0];
        id_ok      = 32'(i_item.sound_id) < 32'(NUM_SOUNDS);
        free_found = 1'b0;
        free_idx   = '0;
        for (int v = NUM_VOICES - 1; v >= 0; v--) begin
            if (!r_busy[v]) begin
                free_found = 1'b1;
                free_idx   = VID_W'(v);
            end
        end
        trig_go = 1'b0;
        wr_go   = 1'b0;
        len_go  = 1'b0;
        if (i_cmd.exec) begin
            case (i_item.command)
                pvm_pkg::CMD_TRIGGER: trig_go = id_ok && r_present[id_idx] && free_found;
                pvm_pkg::CMD_WRITE:   wr_go   = id_ok &&
                                                (32'(i_item.sample_offset) < 32'(SLOT_DEPTH));
                pvm_pkg::CMD_LENGTH:  len_go  = id_ok;
                default: ;
            endcase
        end
        wr_addr = AW'(32'(id_idx) * 32'(SLOT_DEPTH) + 32'(i_item.sample_offset));
        len32   = 32'(i_item.length_value);
        len_sat = (len32 > 32'(SLOT_DEPTH)) ? 32'(SLOT_DEPTH) : len32;
    end

    // Second scan stage: check the live length, advance or free the voice
    always_comb begin
        len_eff   = r_len_ok ? r_len_q : '0;
        pos_ext   = LEN_W'(r_s1_pos);
        pos_inc   = pos_ext + LEN_W'(1);
        s2_upd    = r_s1_vld && r_s1_busy;
        s2_play   = s2_upd && (pos_ext < len_eff);
        s2_busy_n = 1'b0;
        s2_pos_n  = '0;
        if (s2_play && (pos_inc < len_eff)) begin
            s2_busy_n = 1'b1;
            s2_pos_n  = POS_W'(pos_inc);
        end
        rd_addr = AW'(32'(r_s1_sound) * 32'(SLOT_DEPTH) + 32'(r_s1_pos));
    end

    // Busy and present flags, and pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= '0;
            r_present <= '0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
        end else begin
            if (trig_go) begin
                r_busy[free_idx] <= 1'b1;
            end
            if (s2_upd) begin
                r_busy[r_s1_vidx] <= s2_busy_n;
            end
            if (len_go) begin
                r_present[id_idx] <= (len32 != 32'd0);
            end
            r_s1_vld <= i_cmd.scan_step;
            r_s2_vld <= s2_play;
        end
    end

    // Voice sound and position
    always_ff @(posedge i_clk) begin
        if (trig_go) begin
            r_vsound[free_idx] <= id_idx;
            r_vpos[free_idx]   <= '0;
        end
        if (s2_upd) begin
            r_vpos[r_s1_vidx] <= s2_pos_n;
        end
    end

    // First scan stage: voice index and the voice's registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_start) begin
            r_vidx <= '0;
        end else if (i_cmd.scan_step && !o_sts.scan_last) begin
            r_vidx <= r_vidx + 1'b1;
        end
        r_s1_vidx  <= r_vidx;
        r_s1_busy  <= r_busy[r_vidx];
        r_s1_pos   <= r_vpos[r_vidx];
        r_s1_sound <= r_vsound[r_vidx];
    end

    // Length memory
    always_ff @(posedge i_clk) begin
        if (len_go) begin
            r_len_mem[id_idx] <= LEN_W'(len_sat);
        end
        r_len_q  <= r_len_mem[r_vsound[r_vidx]];
        r_len_ok <= r_present[r_vsound[r_vidx]];
    end

    // Sample memory
    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_smp_mem[wr_addr] <= i_item.sample_value;
        end
        if (s2_play) begin
            r_smp_q <= r_smp_mem[rd_addr];
        end
    end

    // Accumulate samples that arrive from the memory
    always_comb begin
        n_sum = r_sum;
        n_cnt = r_cnt;
        if (r_s2_vld) begin
            n_sum = r_sum + SUM_W'(r_smp_q);
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_start) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else begin
            r_sum <= n_sum;
            r_cnt <= n_cnt;
        end
    end

    pvm_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (n_sum),
        .i_divisor  (n_cnt),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // Output register: average, or the plain sum for zero or one voice
    always_comb begin
        cnt32 = 32'(r_cnt);
        avg   = (r_cnt > CNT_W'(1)) ? quotient[pvm_pkg::SAMPLE_W-1:0]
                                    : r_sum[pvm_pkg::SAMPLE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.left_sample   <= avg;
            r_out.right_sample  <= avg;
            r_out.active_voices <= cnt32[pvm_pkg::ACTIVE_W-1:0];
        end
    end

    assign o_sts.scan_last = (r_vidx == VID_W'(NUM_VOICES - 1));
    assign o_sts.div_done  = div_done;
    assign o_item          = r_out;

endmodule

@@ rtl/pvm_ctrl.sv @@
// Controller: sequences command execution, voice scan, divide and output.
`timescale 1ns / 1ps

module pvm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  pvm_pkg::t_cmd    i_command,
    input  logic             i_out_stall,
    input  pvm_pkg::t_dp_sts i_sts,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output pvm_pkg::t_dp_cmd o_cmd
);

    pvm_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pvm_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            pvm_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_command == pvm_pkg::CMD_TICK) begin
                        o_cmd.tick_start = 1'b1;
                        n_state          = pvm_pkg::ST_SCAN;
                    end else begin
                        o_cmd.exec = 1'b1;
                    end
                end
            end
            pvm_pkg::ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = pvm_pkg::ST_DRAIN;
                end
            end
            pvm_pkg::ST_DRAIN: begin
                n_state = pvm_pkg::ST_FINISH;
            end
            pvm_pkg::ST_FINISH: begin
                o_cmd.div_start = 1'b1;
                n_state         = pvm_pkg::ST_DIVIDE;
            end
            pvm_pkg::ST_DIVIDE: begin
                // wait for the quotient and a free output register
                if (i_sts.div_done && (!r_out_valid || !i_out_stall)) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = pvm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pvm_pkg::ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when the transaction completes
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_stall  = (r_state != pvm_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

    // A frame is never loaded over one still waiting to be taken
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten while stalled");

    // A loaded frame is offered on the next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> o_out_valid)
        else $error("loaded frame not offered");

    // The divider drops its done flag once launched
    a_div_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> !i_sts.div_done)
        else $error("divider done flag stale after start");

    // A tick only starts from idle with an accepted transaction
    a_tick_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.tick_start |-> (i_in_valid && !o_in_stall))
        else $error("tick started without an accepted transaction");

endmodule

@@ rtl/pcm_voice_mixer.sv @@
// A trigger, sample write or length set is carried out in idle and does not stall the input.
// A tick stalls the input while the controller scans every voice, drains the scan pipeline,
// launches a one-bit-per-cycle divide over 16 + clog2(NUM_VOICES+1) bits and loads the frame
// into the output register, from which it is offered.
// The mixed frame waits in an output register; a stalled frame holds the next tick's load.
// Reset (synchronous, active low) frees every voice and marks every sound length as unset.
`timescale 1ns / 1ps

module pcm_voice_mixer #(
    parameter int NUM_VOICES = 4,
    parameter int NUM_SOUNDS = 8,
    parameter int SLOT_DEPTH = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pvm_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pvm_pkg::t_out_item o_out_item
);

    pvm_pkg::t_dp_cmd dp_cmd;
    pvm_pkg::t_dp_sts dp_sts;

    pvm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_in_item.command),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (dp_cmd)
    );

    pvm_dp #(
        .NUM_VOICES (NUM_VOICES),
        .NUM_SOUNDS (NUM_SOUNDS),
        .SLOT_DEPTH (SLOT_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in_item),
        .i_cmd   (dp_cmd),
        .o_sts   (dp_sts),
        .o_item  (o_out_item)
    );

endmodule
